[rtl/gda_pkg.sv]
package gda_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CVT,
        ST_OP,
        ST_Q400,
        ST_C100,
        ST_Q4,
        ST_Y1,
        ST_MON,
        ST_WK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [26:0] a;
        logic signed [15:0] b;
        logic signed [31:0] c;
    } t_mac_op;

    localparam logic [2:0] REQ_ADD  = 3'd0;
    localparam logic [2:0] REQ_SUB  = 3'd1;
    localparam logic [2:0] REQ_DIFF = 3'd2;
    localparam logic [2:0] REQ_CMP  = 3'd3;
    localparam logic [2:0] REQ_WDAY = 3'd4;

    localparam logic signed [31:0] DAYS_400Y   = 32'sd146097;
    localparam logic signed [31:0] DAYS_100Y   = 32'sd36524;
    localparam logic signed [31:0] DAYS_4Y     = 32'sd1461;
    localparam logic signed [31:0] DAYS_1Y     = 32'sd365;
    localparam logic signed [31:0] EPOCH_DAYS  = 32'sd1314873;
    localparam logic signed [31:0] LAST_SERIAL = 32'sd3067670;
    localparam logic signed [31:0] YEAR_OFS    = 32'sd1999;
    localparam logic signed [15:0] RECIP_25    = 16'sd5243;
    localparam logic signed [15:0] RECIP_7     = 16'sd9363;
    localparam logic [21:0]        DIST_MAX    = 22'h3FFFFF;
    localparam logic [13:0]        BASE_YEAR   = 14'd1601;

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd0, 4'd1: s = 9'd0;
            4'd2:       s = 9'd31;
            4'd3:       s = 9'd59;
            4'd4:       s = 9'd90;
            4'd5:       s = 9'd120;
            4'd6:       s = 9'd151;
            4'd7:       s = 9'd181;
            4'd8:       s = 9'd212;
            4'd9:       s = 9'd243;
            4'd10:      s = 9'd273;
            4'd11:      s = 9'd304;
            default:    s = 9'd334;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mi);
        logic [4:0] l;
        case (mi)
            4'd1:                     l = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  l = 5'd30;
            default:                  l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

[rtl/gda_req_if.sv]
interface gda_req_if #(
    parameter int DAY_COUNT_BITS = 22
);
    logic                      valid;
    logic                      ready;
    logic [2:0]                req_type;
    logic [4:0]                day_a;
    logic [3:0]                month_a;
    logic [13:0]               year_a;
    logic [4:0]                day_b;
    logic [3:0]                month_b;
    logic [13:0]               year_b;
    logic [DAY_COUNT_BITS-1:0] day_count;

    modport source (output valid, req_type, day_a, month_a, year_a, day_b, month_b,
                    year_b, day_count, input ready);
    modport sink (input valid, req_type, day_a, month_a, year_a, day_b, month_b,
                  year_b, day_count, output ready);
endinterface

[rtl/gda_res_if.sv]
interface gda_res_if;
    logic               valid;
    logic               ready;
    logic [4:0]         res_day;
    logic [3:0]         res_month;
    logic [13:0]        res_year;
    logic [21:0]        day_distance;
    logic signed [14:0] cmp_value;
    logic [2:0]         weekday;
    logic               range_error;

    modport source (output valid, res_day, res_month, res_year, day_distance, cmp_value,
                    weekday, range_error, input ready);
    modport sink (input valid, res_day, res_month, res_year, day_distance, cmp_value,
                  weekday, range_error, output ready);
endinterface

[rtl/gregorian_date_arithmetic_top.sv]
// Channel  Direction  Payload
// i_req    in         req_type, date A, date B, day_count
// o_res    out        result date, day_distance, cmp_value, weekday, range_error
//
// One request at a time; the arithmetic steps run through one shared multiply-add unit,
// while compare and the leap-year test use their own logic. A date becomes a day serial
// in the CVT steps, both dates for difference and date A alone otherwise. Compare and
// difference then finish in OP, weekday in WK; add and subtract rebuild the date by trial
// subtraction. Synchronous active-low reset; the result waits in an output register,
// and a new request is taken while it is stalled.
module gregorian_date_arithmetic_top #(
    parameter int DAY_COUNT_BITS = 22
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gda_req_if.sink    i_req,
    gda_res_if.source  o_res
);
    import gda_pkg::*;

    localparam int CNT_BITS = (DAY_COUNT_BITS < 22) ? DAY_COUNT_BITS : 22;

    t_state             r_state, n_state;
    logic [3:0]         r_step;
    logic               r_sel;
    logic [2:0]         r_op;
    logic [4:0]         r_da, r_db;
    logic [3:0]         r_ma, r_mb;
    logic [13:0]        r_ya, r_yb;
    logic [21:0]        r_cnt;
    logic [14:0]        r_t;
    logic [7:0]         r_q1, r_q3;
    logic [5:0]         r_q2, r_q4;
    logic [10:0]        r_wq;
    logic signed [31:0] r_acc, r_sa;
    logic [13:0]        r_yr;
    logic [1:0]         r_cc, r_c1;
    logic [4:0]         r_c4;
    logic [3:0]         r_mi;

    logic [4:0]         r_rd;
    logic [3:0]         r_rm;
    logic [13:0]        r_ry;
    logic [21:0]        r_dist;
    logic signed [14:0] r_cmp;
    logic [2:0]         r_wd;
    logic               r_rng;

    logic               r_ov;
    logic [4:0]         r_od;
    logic [3:0]         r_om;
    logic [13:0]        r_oy;
    logic [21:0]        r_odist;
    logic signed [14:0] r_ocmp;
    logic [2:0]         r_owd;
    logic               r_orng;

    t_mac_op            w_mac;
    logic signed [31:0] w_res;
    logic [4:0]         w_d;
    logic [3:0]         w_m, w_msat;
    logic [13:0]        w_y;
    logic [11:0]        w_q3x25;
    logic [9:0]         w_q4x25;
    logic               w_leap, w_yleap, w_out_free;
    logic signed [31:0] w_adj, w_abs;
    logic [4:0]         w_len;

    gda_unit u_unit (
        .i_op  (w_mac),
        .o_res (w_res)
    );

    assign w_d     = r_sel ? r_db : r_da;
    assign w_m     = r_sel ? r_mb : r_ma;
    assign w_y     = r_sel ? r_yb : r_ya;
    assign w_msat  = (w_m == 4'd0) ? 4'd1 : ((w_m > 4'd12) ? 4'd12 : w_m);
    assign w_q3x25 = 12'(r_q3) * 12'd25;
    assign w_q4x25 = 10'(r_q4) * 10'd25;
    assign w_leap  = ((w_y[1:0] == 2'd0) && (w_y[13:2] != w_q3x25))
                  || ((w_y[3:0] == 4'd0) && (w_y[13:4] == w_q4x25));
    assign w_adj   = 32'(w_d) + 32'(month_start(w_msat))
                   + 32'((w_leap && (w_msat > 4'd2)) ? 1 : 0) - 32'sd1 - EPOCH_DAYS;
    assign w_yleap = (r_c1 == 2'd3) && ((r_c4 != 5'd24) || (r_cc == 2'd3));
    assign w_len   = month_len(r_mi) + 5'((r_mi == 4'd1 && w_yleap) ? 1 : 0);
    assign w_abs   = (w_res < 0) ? -w_res : w_res;
    assign w_out_free = !r_ov || o_res.ready;

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        w_mac = '0;
        unique case (r_state)
            ST_CVT: begin
                case (r_step)
                    4'd0: begin
                        w_mac.a = 27'(w_y);
                        w_mac.b = 16'sd1;
                        w_mac.c = YEAR_OFS;
                    end
                    4'd1: begin
                        w_mac.a = 27'(r_t[14:2]);
                        w_mac.b = RECIP_25;
                    end
                    4'd2: begin
                        w_mac.a = 27'(r_t[14:4]);
                        w_mac.b = RECIP_25;
                    end
                    4'd3: begin
                        w_mac.a = 27'(w_y[13:2]);
                        w_mac.b = RECIP_25;
                    end
                    4'd4: begin
                        w_mac.a = 27'(w_y[13:4]);
                        w_mac.b = RECIP_25;
                    end
                    4'd5: begin
                        w_mac.a = 27'(r_t);
                        w_mac.b = 16'sd365;
                        w_mac.c = 32'(r_t[14:2]);
                    end
                    4'd6: begin
                        w_mac.a = 27'(r_q1);
                        w_mac.b = -16'sd1;
                        w_mac.c = r_acc;
                    end
                    4'd7: begin
                        w_mac.a = 27'(r_q2);
                        w_mac.b = 16'sd1;
                        w_mac.c = r_acc;
                    end
                    default: begin
                        w_mac.a = r_acc[26:0];
                        w_mac.b = 16'sd1;
                        w_mac.c = w_adj;
                    end
                endcase
            end
            ST_OP: begin
                case (r_op)
                    REQ_ADD: begin
                        w_mac.a = r_sa[26:0];
                        w_mac.b = 16'sd1;
                        w_mac.c = 32'(r_cnt);
                    end
                    REQ_SUB: begin
                        w_mac.a = r_sa[26:0];
                        w_mac.b = 16'sd1;
                        w_mac.c = -32'(r_cnt);
                    end
                    REQ_DIFF: begin
                        w_mac.a = r_acc[26:0];
                        w_mac.b = -16'sd1;
                        w_mac.c = r_sa;
                    end
                    default: begin
                        w_mac.a = r_sa[26:0];
                        w_mac.b = 16'sd1;
                    end
                endcase
            end
            ST_Q400: begin
                w_mac.a = r_acc[26:0];
                w_mac.b = 16'sd1;
                w_mac.c = -DAYS_400Y;
            end
            ST_C100: begin
                w_mac.a = r_acc[26:0];
                w_mac.b = 16'sd1;
                w_mac.c = -DAYS_100Y;
            end
            ST_Q4: begin
                w_mac.a = r_acc[26:0];
                w_mac.b = 16'sd1;
                w_mac.c = -DAYS_4Y;
            end
            ST_Y1: begin
                w_mac.a = r_acc[26:0];
                w_mac.b = 16'sd1;
                w_mac.c = -DAYS_1Y;
            end
            ST_MON: begin
                w_mac.a = r_acc[26:0];
                w_mac.b = 16'sd1;
                w_mac.c = -32'(w_len);
            end
            ST_WK: begin
                case (r_step)
                    4'd0: begin
                        w_mac.a = 27'(r_acc[23:12]);
                        w_mac.b = 16'sd1;
                        w_mac.c = 32'(r_acc[11:0]);
                    end
                    4'd1: begin
                        w_mac.a = r_acc[26:0];
                        w_mac.b = RECIP_7;
                    end
                    default: begin
                        w_mac.a = 27'(r_wq);
                        w_mac.b = -16'sd7;
                        w_mac.c = r_acc;
                    end
                endcase
            end
            default: w_mac = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_CVT;
            ST_CVT: begin
                if (r_step == 4'd8 && (r_sel || r_op != REQ_DIFF)) n_state = ST_OP;
            end
            ST_OP: begin
                case (r_op)
                    REQ_ADD, REQ_SUB: begin
                        if (w_res < 0 || w_res > LAST_SERIAL) n_state = ST_DONE;
                        else n_state = ST_Q400;
                    end
                    REQ_WDAY: n_state = ST_WK;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_Q400: if (w_res < 0) n_state = ST_C100;
            ST_C100: if (w_res < 0 || r_cc == 2'd3) n_state = ST_Q4;
            ST_Q4:   if (w_res < 0) n_state = ST_Y1;
            ST_Y1:   if (w_res < 0 || r_c1 == 2'd3) n_state = ST_MON;
            ST_MON:  if (w_res < 0 || r_mi == 4'd11) n_state = ST_DONE;
            ST_WK:   if (r_step == 4'd2) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state || (r_state == ST_CVT && r_step == 4'd8)) r_step <= '0;
            else r_step <= r_step + 4'd1;
            if (r_state == ST_IDLE) r_sel <= 1'b0;
            else if (r_state == ST_CVT && r_step == 4'd8) r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    r_op   <= i_req.req_type;
                    r_da   <= i_req.day_a;
                    r_ma   <= i_req.month_a;
                    r_ya   <= i_req.year_a;
                    r_db   <= i_req.day_b;
                    r_mb   <= i_req.month_b;
                    r_yb   <= i_req.year_b;
                    r_cnt  <= 22'(i_req.day_count[CNT_BITS-1:0]);
                    r_rd   <= '0;
                    r_rm   <= '0;
                    r_ry   <= '0;
                    r_dist <= '0;
                    r_cmp  <= '0;
                    r_wd   <= '0;
                    r_rng  <= 1'b0;
                end
            end
            ST_CVT: begin
                case (r_step)
                    4'd0:    r_t  <= w_res[14:0];
                    4'd1:    r_q1 <= w_res[24:17];
                    4'd2:    r_q2 <= w_res[22:17];
                    4'd3:    r_q3 <= w_res[24:17];
                    4'd4:    r_q4 <= w_res[22:17];
                    4'd8: begin
                        r_acc <= w_res;
                        if (!r_sel) r_sa <= w_res;
                    end
                    default: r_acc <= w_res;
                endcase
            end
            ST_OP: begin
                r_acc <= (r_op == REQ_WDAY) ? w_abs : w_res;
                r_yr  <= BASE_YEAR;
                r_cc  <= '0;
                r_c4  <= '0;
                r_c1  <= '0;
                r_mi  <= '0;
                case (r_op)
                    REQ_ADD, REQ_SUB: begin
                        if (w_res < 0 || w_res > LAST_SERIAL) r_rng <= 1'b1;
                    end
                    REQ_DIFF: begin
                        r_dist <= (w_abs > 32'(DIST_MAX)) ? DIST_MAX : w_abs[21:0];
                    end
                    REQ_CMP: begin
                        if (r_ya != r_yb) r_cmp <= 15'({1'b0, r_ya}) - 15'({1'b0, r_yb});
                        else if (r_ma != r_mb) r_cmp <= 15'(r_ma) - 15'(r_mb);
                        else r_cmp <= 15'(r_da) - 15'(r_db);
                    end
                    REQ_WDAY: begin
                        r_dist <= (w_abs > 32'(DIST_MAX)) ? DIST_MAX : w_abs[21:0];
                    end
                    default: ;
                endcase
            end
            ST_Q400: begin
                if (w_res >= 0) begin
                    r_acc <= w_res;
                    r_yr  <= r_yr + 14'd400;
                end
            end
            ST_C100: begin
                if (w_res >= 0 && r_cc != 2'd3) begin
                    r_acc <= w_res;
                    r_cc  <= r_cc + 2'd1;
                    r_yr  <= r_yr + 14'd100;
                end
            end
            ST_Q4: begin
                if (w_res >= 0) begin
                    r_acc <= w_res;
                    r_c4  <= r_c4 + 5'd1;
                    r_yr  <= r_yr + 14'd4;
                end
            end
            ST_Y1: begin
                if (w_res >= 0 && r_c1 != 2'd3) begin
                    r_acc <= w_res;
                    r_c1  <= r_c1 + 2'd1;
                    r_yr  <= r_yr + 14'd1;
                end
            end
            ST_MON: begin
                if (w_res >= 0 && r_mi != 4'd11) begin
                    r_acc <= w_res;
                    r_mi  <= r_mi + 4'd1;
                end else begin
                    r_rd <= r_acc[4:0] + 5'd1;
                    r_rm <= r_mi + 4'd1;
                    r_ry <= r_yr;
                end
            end
            ST_WK: begin
                case (r_step)
                    4'd0:    r_acc <= w_res;
                    4'd1:    r_wq  <= w_res[26:16];
                    default: r_wd  <= w_res[2:0];
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_od    <= r_rd;
            r_om    <= r_rm;
            r_oy    <= r_ry;
            r_odist <= r_dist;
            r_ocmp  <= r_cmp;
            r_owd   <= r_wd;
            r_orng  <= r_rng;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.res_day      = r_od;
    assign o_res.res_month    = r_om;
    assign o_res.res_year     = r_oy;
    assign o_res.day_distance = r_odist;
    assign o_res.cmp_value    = r_ocmp;
    assign o_res.weekday      = r_owd;
    assign o_res.range_error  = r_orng;
endmodule

[rtl/gda_unit.sv]
module gda_unit (
    input  gda_pkg::t_mac_op    i_op,
    output logic signed [31:0]  o_res
);
    import gda_pkg::*;

    logic signed [42:0] w_prod;

    assign w_prod = i_op.a * i_op.b;
    assign o_res  = 32'(w_prod) + i_op.c;
endmodule

[tb/sv/gregorian_date_arithmetic_top_test.sv]
module gregorian_date_arithmetic_top_test;
    import gda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
        logic [21:0] day_count;
    } t_date_req;

    typedef struct packed {
        logic [4:0]         res_day;
        logic [3:0]         res_month;
        logic [13:0]        res_year;
        logic [21:0]        day_distance;
        logic signed [14:0] cmp_value;
        logic [2:0]         weekday;
        logic               range_error;
    } t_date_res;

    localparam int N_RANDOM = 1500;
    localparam int CUTOFF = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gda_req_if #(.DAY_COUNT_BITS(22)) req_ch ();
    gda_res_if res_ch ();

    gregorian_date_arithmetic_top #(.DAY_COUNT_BITS(22)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    t_date_req pending_reqs[$];
    t_date_res expected_results[$];
    int        n_errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_range = 0;
    bit        stimulus_done = 0;
    int        hold_off = 0;
    int        res_gap = 0;
    int        res_draw = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit leap_year(longint y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic longint days_to_year(longint y);
        longint t;
        t = y + 1999;
        return t * 365 + t / 4 - t / 100 + t / 400;
    endfunction

    function automatic longint month_offset(longint m);
        longint s[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        return s[m - 1];
    endfunction

    function automatic longint day_serial(longint d, longint m, longint y);
        longint mi;
        longint s;
        mi = m < 1 ? 1 : (m > 12 ? 12 : m);
        s = days_to_year(y) - days_to_year(1601) + month_offset(mi);
        if (mi > 2 && leap_year(y)) s++;
        return s + d - 1;
    endfunction

    function automatic longint clip_distance(longint v);
        if (v < 0) v = -v;
        return v > 4194303 ? 4194303 : v;
    endfunction

    function automatic t_date_res compute_date_result(t_date_req q);
        t_date_res r;
        longint sa, s, last, yr, mlen, c, y1;
        int mi;
        r = '0;
        sa = day_serial(q.day_a, q.month_a, q.year_a);
        case (q.req_type)
            REQ_ADD, REQ_SUB: begin
                last = day_serial(31, 12, 9999);
                s = (q.req_type == REQ_ADD) ? sa + q.day_count : sa - q.day_count;
                if (s < 0 || s > last) begin
                    r.range_error = 1'b1;
                end else begin
                    yr = 1601 + 400 * (s / 146097);
                    s = s % 146097;
                    c = s / 36524;
                    if (c > 3) c = 3;
                    s -= c * 36524;
                    yr += 100 * c + 4 * (s / 1461);
                    s = s % 1461;
                    y1 = s / 365;
                    if (y1 > 3) y1 = 3;
                    s -= y1 * 365;
                    yr += y1;
                    mi = 0;
                    forever begin
                        mlen = (mi == 11) ? 31 : month_offset(mi + 2) - month_offset(mi + 1);
                        if (mi == 1 && leap_year(yr)) mlen++;
                        if (s < mlen || mi == 11) break;
                        s -= mlen;
                        mi++;
                    end
                    r.res_day = 5'(s + 1);
                    r.res_month = 4'(mi + 1);
                    r.res_year = 14'(yr);
                end
            end
            REQ_DIFF: r.day_distance =
                22'(clip_distance(sa - day_serial(q.day_b, q.month_b, q.year_b)));
            REQ_CMP: begin
                if (q.year_a != q.year_b)
                    r.cmp_value = 15'(longint'(q.year_a) - longint'(q.year_b));
                else if (q.month_a != q.month_b)
                    r.cmp_value = 15'(longint'(q.month_a) - longint'(q.month_b));
                else r.cmp_value = 15'(longint'(q.day_a) - longint'(q.day_b));
            end
            REQ_WDAY: begin
                s = sa < 0 ? -sa : sa;
                r.day_distance = 22'(clip_distance(s));
                r.weekday = 3'(s % 7);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_date_req random_request();
        t_date_req q;
        int sel;
        q = '0;
        sel = $urandom_range(0, 19);
        q.req_type = (sel == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        q.day_a = 5'($urandom_range(1, 28));
        q.month_a = 4'($urandom_range(1, 12));
        q.year_a = 14'($urandom_range(1601, 9999));
        q.day_b = 5'($urandom_range(1, 28));
        q.month_b = 4'($urandom_range(1, 12));
        q.year_b = (sel < 4) ? q.year_a : 14'($urandom_range(1601, 9999));
        if (sel == 1) q.month_b = q.month_a;
        if (sel == 2) begin
            q.day_a = 5'($urandom);
            q.month_a = 4'($urandom);
            q.year_a = 14'($urandom);
            q.day_b = 5'($urandom);
            q.month_b = 4'($urandom);
            q.year_b = 14'($urandom);
        end
        case ($urandom_range(0, 3))
            0: q.day_count = 22'($urandom_range(0, 400));
            1: q.day_count = 22'($urandom_range(0, 40000));
            default: q.day_count = 22'($urandom);
        endcase
        return q;
    endfunction

    function automatic t_date_req make_req(logic [2:0] op, int da, int ma, int ya,
                                           int db, int mb, int yb, int cnt);
        t_date_req q;
        q.req_type = op;
        q.day_a = 5'(da);
        q.month_a = 4'(ma);
        q.year_a = 14'(ya);
        q.day_b = 5'(db);
        q.month_b = 4'(mb);
        q.year_b = 14'(yb);
        q.day_count = 22'(cnt);
        return q;
    endfunction

    initial begin
        pending_reqs.push_back(make_req(REQ_ADD, 1, 1, 1601, 1, 1, 1601, 0));
        pending_reqs.push_back(make_req(REQ_ADD, 31, 12, 9999, 1, 1, 1601, 1));
        pending_reqs.push_back(make_req(REQ_ADD, 28, 2, 2000, 1, 1, 1601, 1));
        pending_reqs.push_back(make_req(REQ_ADD, 28, 2, 1900, 1, 1, 1601, 1));
        pending_reqs.push_back(make_req(REQ_ADD, 1, 1, 1601, 1, 1, 1601, 4194303));
        pending_reqs.push_back(make_req(REQ_ADD, 1, 1, 1601, 1, 1, 1601, 3067670));
        pending_reqs.push_back(make_req(REQ_SUB, 1, 1, 1601, 1, 1, 1601, 1));
        pending_reqs.push_back(make_req(REQ_SUB, 31, 12, 9999, 1, 1, 1601, 3067670));
        pending_reqs.push_back(make_req(REQ_SUB, 1, 3, 2400, 1, 1, 1601, 1));
        pending_reqs.push_back(make_req(REQ_DIFF, 1, 1, 1601, 31, 12, 9999, 0));
        pending_reqs.push_back(make_req(REQ_DIFF, 31, 12, 9999, 1, 1, 1601, 0));
        pending_reqs.push_back(make_req(REQ_DIFF, 31, 15, 16383, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_CMP, 1, 1, 1601, 31, 12, 9999, 0));
        pending_reqs.push_back(make_req(REQ_CMP, 31, 12, 9999, 1, 1, 1601, 0));
        pending_reqs.push_back(make_req(REQ_CMP, 5, 7, 2020, 5, 3, 2020, 0));
        pending_reqs.push_back(make_req(REQ_CMP, 1, 7, 2020, 31, 7, 2020, 0));
        pending_reqs.push_back(make_req(REQ_WDAY, 1, 1, 1601, 1, 1, 1601, 0));
        pending_reqs.push_back(make_req(REQ_WDAY, 31, 12, 9999, 1, 1, 1601, 0));
        pending_reqs.push_back(make_req(REQ_WDAY, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_WDAY, 31, 15, 16383, 31, 15, 16383, 0));
        pending_reqs.push_back(make_req(REQ_WDAY, 0, 13, 2000, 1, 1, 1601, 0));
        pending_reqs.push_back(make_req(3'd7, 31, 15, 16383, 31, 15, 16383, 4194303));
        pending_reqs.push_back(make_req(3'd5, 1, 1, 1601, 1, 1, 1601, 0));
        repeat (N_RANDOM) pending_reqs.push_back(random_request());
    end

    // Driver: waits a random number of cycles before offering each transaction.
    int req_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_gap <= $urandom_range(0, 8);
        end else if (req_ch.valid && !req_ch.ready) begin
        end else begin
            if (req_ch.valid) begin
                expected_results.push_back(compute_date_result(
                    {req_ch.req_type, req_ch.day_a, req_ch.month_a, req_ch.year_a,
                     req_ch.day_b, req_ch.month_b, req_ch.year_b, req_ch.day_count}));
                n_sent++;
            end
            if (req_gap > 0 || pending_reqs.size() == 0) begin
                req_ch.valid <= 1'b0;
                if (req_gap > 0) req_gap <= req_gap - 1;
                if (pending_reqs.size() == 0 && !req_ch.valid) stimulus_done <= 1'b1;
            end else begin
                t_date_req q;
                q = pending_reqs.pop_front();
                {req_ch.req_type, req_ch.day_a, req_ch.month_a, req_ch.year_a,
                 req_ch.day_b, req_ch.month_b, req_ch.year_b, req_ch.day_count} <= q;
                req_ch.valid <= 1'b1;
                req_gap <= (n_sent % 50 < 10) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    // Monitor: checks each result, waits a random gap after it, and holds ready low long after the 100th.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_date_res got;
                t_date_res want;
                got = {res_ch.res_day, res_ch.res_month, res_ch.res_year, res_ch.day_distance,
                       res_ch.cmp_value, res_ch.weekday, res_ch.range_error};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.range_error) n_range++;
                    if (got.res_day !== want.res_day || got.res_month !== want.res_month ||
                        got.res_year !== want.res_year ||
                        got.day_distance !== want.day_distance ||
                        got.cmp_value !== want.cmp_value || got.weekday !== want.weekday ||
                        got.range_error !== want.range_error) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        n_errors++;
                    end
                end
                n_checked++;
            end
            if (n_checked == 100 && hold_off == 0) begin
                hold_off <= 600;
                res_ch.ready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end else begin
                if (hold_off == 1) hold_off <= -1;
                if (res_ch.valid && res_ch.ready) begin
                    res_draw = (n_checked % 60 < 10) ? 0 : $urandom_range(0, 8);
                    res_gap <= res_draw;
                    res_ch.ready <= (res_draw == 0);
                end else if (res_gap > 0) begin
                    res_gap <= res_gap - 1;
                    res_ch.ready <= (res_gap == 1);
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_results.size() == 0);
        waited = 0;
        while (waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        $display("Ran %0d requests over all operations, %0d results checked, %0d range errors.",
                 n_sent, n_checked, n_range);
        if (n_errors == 0) begin
            $display("[gregorian_date_arithmetic_top] OK");
        end else begin
            $display("[gregorian_date_arithmetic_top] ERROR");
        end
        $finish;
    end

    initial begin
        #(CUTOFF * 1ms);
        $display("[gregorian_date_arithmetic_top] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/gda_pkg.sv
rtl/gda_req_if.sv
rtl/gda_res_if.sv
rtl/gda_unit.sv
rtl/gregorian_date_arithmetic_top.sv
tb/sv/gregorian_date_arithmetic_top_test.sv
